>>> hw/rtl/tlvol_pkg.sv
// Shared types and constants for the TLV object locator.
// No dependencies; imported by every module of the block.
package tlvol_pkg;

	// Default geometry of the message walk
	localparam int COMMON_HEADER_BYTES_DEF = 8;
	localparam int OFFSET_BITS_DEF         = 16;

	// Fixed field widths of the request and result
	localparam int DATA_W     = 8;
	localparam int CLASS_W    = 8;
	localparam int INDEX_W    = 8;
	localparam int OBJ_OFFS_W = 16;
	localparam int OBJ_TYPE_W = 8;
	localparam int OBJ_LEN_W  = 16;
	localparam int OBJ_HDR_BYTES = 4;

	// Result codes
	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NO_MORE   = 2'd1,
		ST_MISSING   = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	// One input request: one message byte plus search key
	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic               last;
		logic [CLASS_W-1:0] want_class;
		logic [INDEX_W-1:0] want_index;
	} item_t;

	// One result
	typedef struct packed {
		status_t                 status;
		logic [OBJ_OFFS_W-1:0]   offset;
		logic [OBJ_TYPE_W-1:0]   obj_type;
		logic [OBJ_LEN_W-1:0]    length;
	} result_t;

endpackage

>>> hw/rtl/tlvol_in_stage.sv
// Input register of the locator: one request held for the walker.
// Depends on tlvol_pkg.
module tlvol_in_stage
	import tlvol_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item_in,
	input  logic  go,
	output logic  valid_s1,
	output item_t item_s1
);

	// Free slot, or the held request leaves this cycle
	assign in_ready = !valid_s1 || go;

	// Control: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule

>>> hw/rtl/tlvol_walker.sv
// Message walker: byte position, object boundary tracking, header capture,
// class match counting and result decision. Depends on tlvol_pkg.
module tlvol_walker
	import tlvol_pkg::*;
#(
	parameter int COMMON_HEADER_BYTES = COMMON_HEADER_BYTES_DEF,
	parameter int OFFSET_BITS         = OFFSET_BITS_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output logic    produce,
	output result_t res
);

	localparam int W  = OFFSET_BITS;
	localparam int SW = ((OFFSET_BITS > OBJ_LEN_W) ? OFFSET_BITS : OBJ_LEN_W) + 1;
	localparam logic [W-1:0] POS_LIMIT = {W{1'b1}};
	localparam logic [W-1:0] NB_RESET  = W'(COMMON_HEADER_BYTES);

	// Walk state
	logic [W-1:0]         pos_q;
	logic [W-1:0]         nb_q;
	logic [23:0]          gather_q;
	logic [INDEX_W-1:0]   ms_q;
	logic [CLASS_W-1:0]   class_q;
	logic [INDEX_W-1:0]   index_q;
	logic                 ans_q;
	logic                 emnf_q;

	// Next-state values
	logic [W-1:0]         nb_n;
	logic [23:0]          gather_n;
	logic [INDEX_W-1:0]   ms_n;
	logic                 ans_n;
	logic                 emnf_n;

	// Decode helpers
	logic [CLASS_W-1:0]   cls_eff;
	logic [INDEX_W-1:0]   idx_raw;
	logic [INDEX_W-1:0]   idx_eff;
	logic [W-1:0]         diff;
	logic                 in_win;
	logic                 hdr_done;
	logic [OBJ_LEN_W-1:0] hdr_len;
	logic [CLASS_W-1:0]   hdr_cls;
	logic                 match;
	logic [SW-1:0]        nb_sum;
	logic [W+OBJ_OFFS_W-1:0] nb_ext;
	logic [W:0]           pos_inc;

	// Key of this message: fresh on its first byte, latched afterwards
	assign cls_eff = (pos_q == '0) ? item.want_class : class_q;
	assign idx_raw = (pos_q == '0) ? item.want_index : index_q;
	assign idx_eff = (idx_raw == '0) ? INDEX_W'(1) : idx_raw;

	// Object header window: four bytes starting at the boundary
	assign diff     = pos_q - nb_q;
	assign in_win   = (pos_q >= nb_q) && (diff[W-1:2] == '0);
	assign hdr_done = in_win && (diff[1:0] == 2'd3);
	assign hdr_len  = gather_q[23:8];
	assign hdr_cls  = gather_q[7:0];
	assign match    = (hdr_cls == cls_eff);
	assign nb_sum   = SW'(nb_q) + SW'(hdr_len);
	assign nb_ext   = {{OBJ_OFFS_W{1'b0}}, nb_q};
	assign pos_inc  = {1'b0, pos_q} + (W+1)'(1);

	// Decision for the current byte
	always_comb begin
		nb_n     = nb_q;
		gather_n = gather_q;
		ms_n     = ms_q;
		ans_n    = ans_q;
		emnf_n   = emnf_q;
		produce  = 1'b0;
		res      = '{status: ST_MISSING, offset: '0, obj_type: '0, length: '0};
		if (!ans_q) begin
			if (pos_q == POS_LIMIT) begin
				res.status = ST_MALFORMED;
				produce    = 1'b1;
				ans_n      = 1'b1;
			end else if (in_win) begin
				gather_n = {gather_q[15:0], item.data};
				if (hdr_done) begin
					if (match && (({1'b0, ms_q} + (INDEX_W+1)'(1)) == {1'b0, idx_eff})) begin
						res.status   = ST_FOUND;
						res.offset   = nb_ext[OBJ_OFFS_W-1:0];
						res.obj_type = item.data;
						res.length   = hdr_len;
						produce      = 1'b1;
						ans_n        = 1'b1;
					end else if (!match && (hdr_len < OBJ_LEN_W'(OBJ_HDR_BYTES))) begin
						res.status = ST_MALFORMED;
						produce    = 1'b1;
						ans_n      = 1'b1;
					end else begin
						if (match) begin
							ms_n = ms_q + INDEX_W'(1);
						end
						// Boundary past the position range saturates
						if (nb_sum > SW'(POS_LIMIT)) begin
							nb_n   = POS_LIMIT;
							emnf_n = 1'b0;
						end else begin
							nb_n   = nb_sum[W-1:0];
							emnf_n = match;
						end
					end
				end
			end
			// Message end without an answer
			if (item.last && !ans_n) begin
				if ((pos_inc == {1'b0, nb_n}) && emnf_n) begin
					res.status = ST_NO_MORE;
				end else begin
					res.status = ST_MISSING;
				end
				produce = 1'b1;
				ans_n   = 1'b1;
			end
		end
	end

	// State update per accepted byte; end of message restarts the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			nb_q     <= NB_RESET;
			gather_q <= '0;
			ms_q     <= '0;
			class_q  <= '0;
			index_q  <= INDEX_W'(1);
			ans_q    <= 1'b0;
			emnf_q   <= 1'b1;
		end else if (fire) begin
			if (pos_q == '0) begin
				class_q <= item.want_class;
				index_q <= idx_eff;
			end
			if (item.last) begin
				pos_q    <= '0;
				nb_q     <= NB_RESET;
				gather_q <= '0;
				ms_q     <= '0;
				ans_q    <= 1'b0;
				emnf_q   <= 1'b1;
			end else begin
				if (pos_q != POS_LIMIT) begin
					pos_q <= pos_inc[W-1:0];
				end
				nb_q     <= nb_n;
				gather_q <= gather_n;
				ms_q     <= ms_n;
				ans_q    <= ans_n;
				emnf_q   <= emnf_n;
			end
		end
	end

endmodule

>>> hw/rtl/tlvol_result_reg.sv
// Output register holding one result until taken.
// Depends on tlvol_pkg.
module tlvol_result_reg
	import tlvol_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t res_q,
	output logic    go
);

	// Stage may advance when the slot is free or being emptied
	assign go = !out_valid || out_ready;

	// Control: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

>>> hw/rtl/tlv_object_locator_core.sv
// TLV object locator: input register -> walker -> output register.
// The deciding byte is held in the input register; the walker's result is
// registered in the output register. One byte per cycle while the result side
// is ready; a held result stalls the input register and the walker.
// Reset (arst_n low, asynchronous): walk restarts at position 0, key 0/1,
// no result pending. Depends on tlvol_pkg and the tlvol_* submodules.
module tlv_object_locator_core
	import tlvol_pkg::*;
#(
	parameter int COMMON_HEADER_BYTES = COMMON_HEADER_BYTES_DEF,
	parameter int OFFSET_BITS         = OFFSET_BITS_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_W-1:0]     data_byte,
	input  logic                  last_byte,
	input  logic [CLASS_W-1:0]    want_class,
	input  logic [INDEX_W-1:0]    want_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [OBJ_OFFS_W-1:0] object_offset,
	output logic [OBJ_TYPE_W-1:0] object_type,
	output logic [OBJ_LEN_W-1:0]  object_length
);

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    go;
	logic    fire;
	logic    produce;
	result_t res_new;
	result_t res_q;

	assign item_in = '{data: data_byte, last: last_byte,
		want_class: want_class, want_index: want_index};
	assign fire = valid_s1 && go;

	tlvol_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.go       (go),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tlvol_walker #(
		.COMMON_HEADER_BYTES (COMMON_HEADER_BYTES),
		.OFFSET_BITS         (OFFSET_BITS)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.produce (produce),
		.res     (res_new)
	);

	tlvol_result_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && produce),
		.res_in    (res_new),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q),
		.go        (go)
	);

	assign status        = res_q.status;
	assign object_offset = res_q.offset;
	assign object_type   = res_q.obj_type;
	assign object_length = res_q.length;

endmodule

>>> hw/rtl/tlvol_checker.sv
// Port-level checks for the TLV object locator, bound to the top level.
// Depends on tlvol_pkg and tlv_object_locator_core.
module tlvol_checker
	import tlvol_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            status,
	input logic [OBJ_OFFS_W-1:0] object_offset,
	input logic [OBJ_TYPE_W-1:0] object_type,
	input logic [OBJ_LEN_W-1:0]  object_length
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(object_offset) && $stable(object_type) && $stable(object_length))
		else $error("result changed while stalled");

	// Not-found results carry zero object fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_FOUND) |->
			(object_offset == '0) && (object_type == '0) && (object_length == '0))
		else $error("not-found result with object fields set");

	// Nothing is offered right after reset
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind tlv_object_locator_core tlvol_checker u_tlvol_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.object_offset (object_offset),
	.object_type   (object_type),
	.object_length (object_length)
);

>>> test/tlv_object_locator_core_tb.sv
// Self-checking testbench for tlv_object_locator_core: byte-serial messages in,
// one lookup result per message out, checked against an in-bench walker model.
// Depends on tlvol_pkg and the tlv_object_locator_core RTL.
`timescale 1ns / 1ps

import tlvol_pkg::*;

// Highest byte position the walk can hold before it flags the message as malformed
localparam int unsigned LAST_POSITION = (1 << OFFSET_BITS_DEF) - 1;

// Walks each message alongside the block and holds the results it should give
class locator_scoreboard;
	int unsigned position;
	int unsigned boundary;
	logic [31:0] gather;
	int unsigned match_count;
	logic [7:0]  key_class;
	int unsigned key_index;
	bit          answered;
	bit          end_no_more;

	result_t     expected_answers[$];
	int          errors;
	int          checked;
	int          status_seen[4];

	function new();
		restart();
		key_class = '0;
		key_index = 1;
	endfunction

	function void restart();
		position    = 0;
		boundary    = COMMON_HEADER_BYTES_DEF;
		gather      = '0;
		match_count = 0;
		answered    = 1'b0;
		end_no_more = 1'b1;
	endfunction

	function void answer(status_t st, int unsigned off, logic [7:0] typ, logic [15:0] len);
		result_t r;
		r.status   = st;
		r.offset   = off[15:0];
		r.obj_type = typ;
		r.length   = len;
		expected_answers.push_back(r);
		answered = 1'b1;
	endfunction

	// Advance the walk by one accepted request byte
	function void note_request(logic [7:0] d, logic lst, logic [7:0] cls, logic [7:0] idx);
		logic [15:0] hlen;
		bit          hit;
		int unsigned nb;
		if (position == 0) begin
			key_class = cls;
			key_index = (idx == 8'd0) ? 1 : idx;
		end
		if (!answered) begin
			if (position >= LAST_POSITION) begin
				answer(ST_MALFORMED, 0, '0, '0);
			end else if (position >= boundary && position < boundary + OBJ_HDR_BYTES) begin
				gather = {gather[23:0], d};
				if (position == boundary + OBJ_HDR_BYTES - 1) begin
					hlen = gather[31:16];
					hit  = (gather[15:8] == key_class);
					if (hit && match_count + 1 == key_index) begin
						answer(ST_FOUND, boundary, gather[7:0], hlen);
					end else if (!hit && hlen < OBJ_HDR_BYTES) begin
						answer(ST_MALFORMED, 0, '0, '0);
					end else begin
						nb = boundary + hlen;
						if (hit)
							match_count = (match_count + 1) & 8'hFF;
						end_no_more = hit;
						// boundary past the position range pins there; end code becomes missing
						if (nb > LAST_POSITION) begin
							nb = LAST_POSITION;
							end_no_more = 1'b0;
						end
						boundary = nb;
					end
				end
			end
			if (lst && !answered) begin
				if (position + 1 == boundary && end_no_more)
					answer(ST_NO_MORE, 0, '0, '0);
				else
					answer(ST_MISSING, 0, '0, '0);
			end
		end
		if (lst)
			restart();
		else if (position < LAST_POSITION)
			position++;
	endfunction

	// Compare one accepted result with the oldest expected one
	function void check_result(logic [1:0] st, logic [15:0] off, logic [7:0] typ,
		logic [15:0] len);
		result_t want;
		if (expected_answers.size() == 0) begin
			$display("%0t: result with none expected: status %0d offset %0d type %0d length %0d",
				$time, st, off, typ, len);
			errors++;
			return;
		end
		want = expected_answers.pop_front();
		checked++;
		status_seen[want.status]++;
		if (st !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, st);
			errors++;
		end
		if (off !== want.offset) begin
			$display("%0t: object_offset expected %0d actual %0d", $time, want.offset, off);
			errors++;
		end
		if (typ !== want.obj_type) begin
			$display("%0t: object_type expected %0d actual %0d", $time, want.obj_type, typ);
			errors++;
		end
		if (len !== want.length) begin
			$display("%0t: object_length expected %0d actual %0d", $time, want.length, len);
			errors++;
		end
	endfunction
endclass

module tlv_object_locator_core_tb;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [DATA_W-1:0]     data_byte;
	logic                  last_byte;
	logic [CLASS_W-1:0]    want_class;
	logic [INDEX_W-1:0]    want_index;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            status;
	logic [OBJ_OFFS_W-1:0] object_offset;
	logic [OBJ_TYPE_W-1:0] object_type;
	logic [OBJ_LEN_W-1:0]  object_length;

	locator_scoreboard sb;

	logic [7:0] msg[$];
	bit         send_gaps;
	bit         recv_stalls;
	int         stall_left;
	int         items_sent;
	int         messages_sent;

	tlv_object_locator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.want_class    (want_class),
		.want_index    (want_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.object_offset (object_offset),
		.object_type   (object_type),
		.object_length (object_length)
	);

	always #4 clk = ~clk;

	// Result side: ready drops in random bursts
	always @(negedge clk) begin
		if (recv_stalls && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Accepted requests feed the walker; accepted results get checked
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(data_byte, last_byte, want_class, want_index);
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, object_offset, object_type, object_length);
	end

	// Present one request and hold it until accepted; returns on a falling edge
	task automatic send_byte(input logic [7:0] d, input logic lst, input logic [7:0] cls,
		input logic [7:0] idx);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= d;
		last_byte  <= lst;
		want_class <= cls;
		want_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic msg_pad(input int n);
		repeat (n) msg.push_back(8'($urandom));
	endtask

	task automatic msg_object(input logic [15:0] len, input logic [7:0] cls,
		input logic [7:0] typ, input int body);
		msg.push_back(len[15:8]);
		msg.push_back(len[7:0]);
		msg.push_back(cls);
		msg.push_back(typ);
		msg_pad(body);
	endtask

	// Key rides on the first byte; later bytes carry random key fields the block ignores
	task automatic send_message(input logic [7:0] cls, input logic [7:0] idx);
		for (int i = 0; i < msg.size(); i++) begin
			if (i == 0)
				send_byte(msg[i], msg.size() == 1, cls, idx);
			else
				send_byte(msg[i], i == msg.size() - 1, 8'($urandom), 8'($urandom));
		end
		messages_sent++;
	endtask

	// Mostly well-formed messages with random objects and endings, some noise
	task automatic random_message();
		int          cut;
		logic [7:0]  cls;
		logic [7:0]  idx;
		logic [7:0]  oc;
		logic [15:0] len;
		cls = 8'($urandom);
		idx = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		msg.delete();
		if ($urandom_range(0, 9) == 0) begin
			msg_pad($urandom_range(1, 24));
		end else begin
			msg_pad(COMMON_HEADER_BYTES_DEF);
			repeat ($urandom_range(0, 4)) begin
				oc  = $urandom_range(0, 1) ? cls : 8'($urandom);
				len = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(0, 3))
					: 16'($urandom_range(4, 14));
				msg_object(len, oc, 8'($urandom), (len > 16'd4) ? int'(len) - 4 : 0);
			end
			case ($urandom_range(0, 3))
				2: begin
					cut = $urandom_range(1, msg.size());
					while (msg.size() > cut)
						void'(msg.pop_back());
				end
				3: msg_pad($urandom_range(1, 6));
				default: ;
			endcase
		end
		send_message(cls, idx);
	endtask

	initial begin
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = '0;
		last_byte     = 1'b0;
		want_class    = '0;
		want_index    = '0;
		out_ready     = 1'b0;
		send_gaps     = 1'b1;
		recv_stalls   = 1'b1;
		stall_left    = 0;
		items_sent    = 0;
		messages_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// single byte: ends inside the common header
		msg.delete();
		msg.push_back(8'h00);
		send_message(8'h00, 8'h01);
		// common header only: ends at the first boundary, nothing there
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		send_message(8'hFF, 8'hFF);
		// first object matches, empty body
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd4, 8'h00, 8'hFF, 0);
		send_message(8'h00, 8'h01);
		// occurrence zero counts as first; trailing bytes after the answer
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd7, 8'hFF, 8'h00, 3);
		msg_pad(2);
		send_message(8'hFF, 8'h00);
		// skip, then a counted match that is not the wanted one, end at boundary
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd6, 8'h11, 8'h01, 2);
		msg_object(16'd5, 8'h22, 8'h02, 1);
		send_message(8'h22, 8'h02);
		// end at boundary right after a skipped object
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd6, 8'h11, 8'h01, 2);
		send_message(8'h22, 8'h01);
		// end inside the next object header
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd9, 8'h22, 8'h03, 5);
		msg_pad(2);
		send_message(8'h22, 8'h02);
		// end inside an object body
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd20, 8'h33, 8'h04, 5);
		send_message(8'h44, 8'h01);
		// skipped object with a short length
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd2, 8'h55, 8'h05, 0);
		msg_pad(4);
		send_message(8'h66, 8'h01);
		// counted match with zero length: boundary does not move
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd0, 8'h77, 8'h06, 0);
		msg_pad(3);
		send_message(8'h77, 8'h02);
		// found object longer than the message
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'hFFFF, 8'h88, 8'h07, 3);
		send_message(8'h88, 8'h01);
		// skipped object whose end lies past the position range
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'hFFFF, 8'h01, 8'h08, 2);
		send_message(8'h02, 8'h01);
		// top occurrence never reached
		msg.delete();
		msg_pad(COMMON_HEADER_BYTES_DEF);
		msg_object(16'd4, 8'hAB, 8'h09, 0);
		msg_object(16'd4, 8'hAB, 8'h0A, 0);
		send_message(8'hAB, 8'hFF);

		// random part; idling switched per message, none near the end
		while (items_sent < 750) begin
			if (items_sent < 650) begin
				send_gaps   = ($urandom_range(0, 3) != 0);
				recv_stalls = ($urandom_range(0, 3) != 0);
			end else begin
				send_gaps   = 1'b0;
				recv_stalls = 1'b0;
			end
			random_message();
		end
		in_valid <= 1'b0;

		while (sb.expected_answers.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Walked %0d messages (%0d bytes), checked %0d results:",
			messages_sent, items_sent, sb.checked);
		$display("  found %0d, end at boundary %0d, missing %0d, malformed %0d",
			sb.status_seen[ST_FOUND], sb.status_seen[ST_NO_MORE],
			sb.status_seen[ST_MISSING], sb.status_seen[ST_MALFORMED]);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard stop if the handshakes hang
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
